// ----- rtl/core/backslash_escape_decoder_macros.svh -----
// assertion macros used by the decoder checker module
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BED_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder check failed");

// next-cycle implication, disabled during reset
`define BED_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder check failed");

`endif

// ----- rtl/core/bed_pkg.sv -----
// shared types, character codes and helper functions of the escape decoder
`timescale 1ns / 1ps

package bed_pkg;

   // character codes
   localparam logic [7:0] CH_BSL = 8'h5C;
   localparam logic [7:0] CH_X   = 8'h78;
   localparam logic [7:0] CH_C   = 8'h63;
   localparam logic [7:0] CTRL_LO = 8'd64;
   localparam logic [7:0] CTRL_HI = 8'd96;

   // number of result slots per item
   localparam int unsigned NUM_SLOTS = 4;

   // input item
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_run_last;
      logic       out_string_end;
   } rsp_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   // outcome of looking at the escape so far
   typedef enum logic [1:0] {
      CLS_OK,
      CLS_MORE,
      CLS_FAIL
   } cls_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic [1:0] sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] res_cnt;
   } sts_type;

   // octal digit test
   function automatic logic is_oct(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h37);
   endfunction

   // hex digit: {valid, nibble}
   function automatic logic [4:0] hex_digit(logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   // single-letter escapes: {valid, value}
   function automatic logic [8:0] letter_escape(logic [7:0] c);
      logic [8:0] r;
      r = '0;
      unique case (c)
         8'h61:   r = {1'b1, 8'd7};
         8'h62:   r = {1'b1, 8'd8};
         8'h65:   r = {1'b1, 8'd27};
         8'h66:   r = {1'b1, 8'd12};
         8'h6E:   r = {1'b1, 8'd10};
         8'h72:   r = {1'b1, 8'd13};
         8'h74:   r = {1'b1, 8'd9};
         8'h76:   r = {1'b1, 8'd11};
         CH_BSL:  r = {1'b1, CH_BSL};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/bed_ctrl.sv -----
// controller: accepts items and steps the result buffer out one item a cycle while rsp_ready is high
`timescale 1ns / 1ps

module bed_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bed_pkg::sts_type sts,
   output bed_pkg::cmd_type cmd
);
   import bed_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] last_ff, last_in;
   logic       load;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         last_ff  <= last_in;
      end
   end

   // next state and handshakes
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sel_ff == last_ff) begin
                  req_ready = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  sel_in = sel_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a new item refills the buffer
      load = req_valid && req_ready;
      if (load && sts.res_cnt != 3'd0) begin
         state_in = ST_SEND;
         sel_in   = '0;
         last_in  = 2'(sts.res_cnt - 3'd1);
      end
      cmd.load = load;
      cmd.sel  = sel_ff;
   end

endmodule

// ----- rtl/core/bed_dp.sv -----
// datapath: escape state, decode of one item and the result buffer
`timescale 1ns / 1ps

module bed_dp (
   input  logic             clock,
   input  logic             reset,
   input  bed_pkg::req_type req_item,
   output bed_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   input  logic             csr_wdata,
   input  bed_pkg::cmd_type cmd,
   output bed_pkg::sts_type sts
);
   import bed_pkg::*;

   logic       allow_ff;
   logic       esc_ff, esc_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] pend_ff [2];
   logic [7:0] pend_in [2];
   rsp_type    res_ff [NUM_SLOTS];

   logic [7:0] b;
   logic       last;
   logic [7:0] ent [NUM_SLOTS];
   logic [2:0] n;
   cls_type    cls;
   logic [7:0] val;
   logic [8:0] let_r;
   logic [4:0] hx_b, hx_1;
   logic [8:0] oct_v;
   logic       do_plain;

   assign b    = req_item.in_byte;
   assign last = req_item.in_last;

   // control state and register
   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b0;
         esc_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (csr_valid) allow_ff <= csr_wdata;
         if (cmd.load) begin
            esc_ff <= esc_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   // held bytes and result buffer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pend_ff[0] <= pend_in[0];
         pend_ff[1] <= pend_in[1];
         for (int i = 0; i < NUM_SLOTS; i++) begin
            res_ff[i].out_byte       <= ent[i];
            res_ff[i].out_run_last   <= (3'(i) == 3'(n - 3'd1));
            res_ff[i].out_string_end <= (3'(i) == 3'(n - 3'd1)) && last;
         end
      end
   end

   // classify the escape including the new byte
   always_comb begin
      let_r = letter_escape(b);
      hx_b  = hex_digit(b);
      hx_1  = hex_digit(pend_ff[1]);
      oct_v = {pend_ff[0][2:0], pend_ff[1][2:0], b[2:0]};
      cls   = CLS_FAIL;
      val   = '0;
      if (cnt_ff == 2'd0) begin
         if (let_r[8]) begin
            cls = CLS_OK;
            val = let_r[7:0];
         end else if (is_oct(b) || b == CH_X || b == CH_C) begin
            cls = CLS_MORE;
         end
      end else if (is_oct(pend_ff[0])) begin
         if (is_oct(b)) begin
            if (cnt_ff == 2'd1) begin
               cls = CLS_MORE;
            end else if (!oct_v[8] && (oct_v[7:0] != 8'd0 || allow_ff)) begin
               cls = CLS_OK;
               val = oct_v[7:0];
            end
         end
      end else if (pend_ff[0] == CH_X) begin
         if (hx_b[4]) begin
            if (cnt_ff == 2'd1) begin
               cls = CLS_MORE;
            end else if ({hx_1[3:0], hx_b[3:0]} != 8'd0) begin
               cls = CLS_OK;
               val = {hx_1[3:0], hx_b[3:0]};
            end
         end
      end else if (pend_ff[0] == CH_C && b > CTRL_LO && b < CTRL_HI) begin
         cls = CLS_OK;
         val = 8'(b - CTRL_LO);
      end
   end

   // build the result list and the next escape state
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) ent[i] = '0;
      n          = '0;
      esc_in     = esc_ff;
      cnt_in     = cnt_ff;
      pend_in[0] = pend_ff[0];
      pend_in[1] = pend_ff[1];
      do_plain   = 1'b0;
      if (!esc_ff) begin
         do_plain = 1'b1;
      end else begin
         unique case (cls)
            CLS_OK: begin
               ent[n[1:0]] = val;
               n           = n + 3'd1;
               esc_in      = 1'b0;
               cnt_in      = '0;
            end
            CLS_MORE: begin
               if (last) begin
                  // string ends inside the escape: flush it literally
                  ent[n[1:0]] = CH_BSL;
                  n           = n + 3'd1;
                  for (int i = 0; i < 2; i++) begin
                     if (2'(i) < cnt_ff) begin
                        ent[n[1:0]] = pend_ff[i];
                        n           = n + 3'd1;
                     end
                  end
                  ent[n[1:0]] = b;
                  n           = n + 3'd1;
               end else begin
                  esc_in              = 1'b1;
                  cnt_in              = cnt_ff + 2'd1;
                  pend_in[cnt_ff[0]] = b;
               end
            end
            CLS_FAIL: begin
               // backslash and held bytes go out, failing byte is re-fed
               ent[n[1:0]] = CH_BSL;
               n           = n + 3'd1;
               for (int i = 0; i < 2; i++) begin
                  if (2'(i) < cnt_ff) begin
                     ent[n[1:0]] = pend_ff[i];
                     n           = n + 3'd1;
                  end
               end
               esc_in   = 1'b0;
               cnt_in   = '0;
               do_plain = 1'b1;
            end
            default: begin
               esc_in = 1'b0;
               cnt_in = '0;
            end
         endcase
      end
      // ordinary character handling
      if (do_plain) begin
         if (b == CH_BSL && !last) begin
            esc_in = 1'b1;
            cnt_in = '0;
         end else begin
            ent[n[1:0]] = b;
            n           = n + 3'd1;
         end
      end
      if (last) begin
         esc_in = 1'b0;
         cnt_in = '0;
      end
      sts.res_cnt = n;
   end

   // result item on the port
   assign rsp_item = res_ff[cmd.sel];

endmodule

// ----- rtl/core/backslash_escape_decoder.sv -----
// Streaming C-style backslash escape decoder. Each accepted byte is decoded
// against the escape held so far and yields zero to four result bytes, which
// are loaded into a four-entry result buffer and leave one per cycle while
// rsp_ready is high. An item that yields no result does not stall the input;
// while the buffer drains the input is stalled, since the drain paces the
// block, and the next item is accepted on the same edge as the last result of
// the one before. Sustained rate is one byte per cycle for plain text while
// rsp_ready is high; the item that breaks an escape yields up to four results
// (backslash, two held bytes and the failing byte). Holding rsp_ready low
// stalls the result side and the input with it.
`timescale 1ns / 1ps

module backslash_escape_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bed_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bed_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);
   import bed_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencing of items and results
   bed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // decode and result storage
   bed_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ----- rtl/core/bed_checker.sv -----
// port-level checks of the escape decoder and their binding
`timescale 1ns / 1ps
`include "backslash_escape_decoder_macros.svh"

module bed_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bed_pkg::req_type req_item,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bed_pkg::rsp_type rsp_item
);

   logic req_take;
   logic rsp_end;

   // accepted input item and flagged string end on the result side
   assign req_take = req_valid && req_ready;
   assign rsp_end  = rsp_valid && rsp_item.out_string_end;

   // a waiting result item holds
   `BED_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // no new item while a result is stalled
   `BED_ASSERT_IMP(a_no_take_stalled, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // a string end always yields a result
   `BED_ASSERT_NXT(a_end_yields, clock, reset, req_take && req_item.in_last, rsp_valid)

   // string end marks the last result of its item
   `BED_ASSERT_IMP(a_end_is_run_last, clock, reset, rsp_end, rsp_item.out_run_last)

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (.*);
